// ===== hdl/cim_pkg.sv =====
// cim_pkg: shared widths, codes and denomination tables of the coin inventory block
// no dependencies; used by cim_mul and coin_inventory_change_maker
`timescale 1ns / 1ps

package cim_pkg;

    // number of denominations that carry a face value
    localparam int KNOWN_DENOMS = 10;

    // field widths fixed by the interface
    localparam int FUNC_BITS   = 2;
    localparam int DIDX_BITS   = 4;
    localparam int FIELD_BITS  = 16;
    localparam int STATUS_BITS = 3;

    // shared multiplier operand and product widths
    localparam int MUL_A_BITS = 16;
    localparam int MUL_B_BITS = 32;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // operation codes
    localparam logic [FUNC_BITS-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FN_CHANGE = 2'd2;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_CHANGE = 3'd2,
        ST_BAD_DENOM = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    // face value in cents, index 0 is 5c
    localparam logic [12:0] DENOM_VALUE [KNOWN_DENOMS] = '{
        13'd5, 13'd10, 13'd20, 13'd50, 13'd100,
        13'd200, 13'd500, 13'd1000, 13'd2000, 13'd5000
    };

    // ceil(2^32 / value): floor(x * recip / 2^32) is exact for any 16-bit x
    localparam logic [31:0] DENOM_RECIP [KNOWN_DENOMS] = '{
        32'((64'h1_0000_0000 + 64'd4) / 64'd5),
        32'((64'h1_0000_0000 + 64'd9) / 64'd10),
        32'((64'h1_0000_0000 + 64'd19) / 64'd20),
        32'((64'h1_0000_0000 + 64'd49) / 64'd50),
        32'((64'h1_0000_0000 + 64'd99) / 64'd100),
        32'((64'h1_0000_0000 + 64'd199) / 64'd200),
        32'((64'h1_0000_0000 + 64'd499) / 64'd500),
        32'((64'h1_0000_0000 + 64'd999) / 64'd1000),
        32'((64'h1_0000_0000 + 64'd1999) / 64'd2000),
        32'((64'h1_0000_0000 + 64'd4999) / 64'd5000)
    };

endpackage

// ===== hdl/cim_mul.sv =====
// cim_mul: shared 16 x 32 multiplier with a registered product
// depends on cim_pkg for operand widths
`timescale 1ns / 1ps

module cim_mul (
    input  logic                          i_clk,
    input  logic [cim_pkg::MUL_A_BITS-1:0] i_a,
    input  logic [cim_pkg::MUL_B_BITS-1:0] i_b,
    output logic [cim_pkg::PROD_BITS-1:0]  o_prod
);

    logic [cim_pkg::PROD_BITS-1:0] r_prod;

    // one product per cycle, no reset on payload
    always_ff @(posedge i_clk) begin
        r_prod <= cim_pkg::PROD_BITS'(i_a) * cim_pkg::PROD_BITS'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/cim_store.sv =====
// cim_store: per-denomination coin counts, cleared at reset, one read and one write port
// no package dependencies
`timescale 1ns / 1ps

module cim_store #(
    parameter int DEPTH      = 10,
    parameter int COUNT_BITS = 16,
    parameter int IDX_BITS   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_BITS-1:0]   i_rd_idx,
    output logic [COUNT_BITS-1:0] o_rd_data,
    input  logic                  i_we,
    input  logic [IDX_BITS-1:0]   i_wr_idx,
    input  logic [COUNT_BITS-1:0] i_wr_data
);

    logic [COUNT_BITS-1:0] r_count [DEPTH];

    // count registers, all zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_we) begin
            r_count[i_wr_idx] <= i_wr_data;
        end
    end

    // read by index
    assign o_rd_data = r_count[i_rd_idx];

endmodule

// ===== hdl/coin_inventory_change_maker.sv =====
// coin_inventory_change_maker: top level, command sequencer around the count store
// depends on cim_pkg, cim_mul and cim_store
`timescale 1ns / 1ps

// Coin inventory with greedy change making. A command is taken when start is high and
// busy is low; func 3 is dropped without a result and without raising busy. Add and
// remove pass through the edit state to their single result. Make-change runs the
// shared multiplier through S_DIV, S_CAP and S_SUB for each denomination (quotient by
// reciprocal, capped take times face value, remainder update), largest first, then a
// check state, then the emit state walks down to the smallest used denomination,
// committing and emitting results. Each result beat is on the o_ ports for exactly
// one cycle with o_valid high and must be taken then: the receiver has no way to
// stall. Results of one make-change come largest denomination first, with o_valid
// low for each unused denomination that the walk passes, o_last marks the final
// beat, and busy is already low while that beat is shown.
module coin_inventory_change_maker #(
    parameter int NUM_DENOMS = 10,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cim_pkg::FUNC_BITS-1:0]   i_func,
    input  logic [cim_pkg::DIDX_BITS-1:0]   i_denom,
    input  logic [cim_pkg::FIELD_BITS-1:0]  i_count,
    input  logic [cim_pkg::FIELD_BITS-1:0]  i_amount,
    output logic                            o_valid,
    output logic [cim_pkg::STATUS_BITS-1:0] o_status,
    output logic [cim_pkg::DIDX_BITS-1:0]   o_denom_out,
    output logic [cim_pkg::FIELD_BITS-1:0]  o_coin_count,
    output logic                            o_last
);

    localparam int ND = (NUM_DENOMS < cim_pkg::KNOWN_DENOMS) ? NUM_DENOMS
                                                              : cim_pkg::KNOWN_DENOMS;
    localparam int IW = (ND > 1) ? $clog2(ND) : 1;
    localparam int WC = (COUNT_BITS > cim_pkg::FIELD_BITS) ? COUNT_BITS
                                                            : cim_pkg::FIELD_BITS;
    localparam int FB = cim_pkg::FIELD_BITS;
    localparam int PB = cim_pkg::PROD_BITS;
    localparam logic [WC:0] COUNT_MAX = (WC+1)'({COUNT_BITS{1'b1}});

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDIT,
        S_DIV,
        S_CAP,
        S_SUB,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state                          r_state, n_state;
    logic [cim_pkg::FUNC_BITS-1:0]   r_func, n_func;
    logic [cim_pkg::DIDX_BITS-1:0]   r_denom, n_denom;
    logic [FB-1:0]                   r_count, n_count;
    logic [FB-1:0]                   r_rem, n_rem;
    logic [IW-1:0]                   r_j, n_j;
    logic [FB-1:0]                   r_take [ND];
    logic [FB-1:0]                   n_take [ND];
    logic [ND-1:0]                   r_nz, n_nz;
    logic                            r_valid, n_valid;
    logic [cim_pkg::STATUS_BITS-1:0] r_status, n_status;
    logic [cim_pkg::DIDX_BITS-1:0]   r_dout, n_dout;
    logic [FB-1:0]                   r_cout, n_cout;
    logic                            r_last, n_last;

    logic [IW-1:0]                   idx;
    logic [COUNT_BITS-1:0]           rd_data;
    logic                            wr_en;
    logic [COUNT_BITS-1:0]           wr_data;
    logic [cim_pkg::MUL_A_BITS-1:0]  mul_a;
    logic [cim_pkg::MUL_B_BITS-1:0]  mul_b;
    logic [PB-1:0]                   prod;
    logic [cim_pkg::DIDX_BITS-1:0]   j4;
    logic [ND-1:0]                   below;
    logic [WC:0]                     sum;
    logic [FB-1:0]                   quot;
    logic [FB-1:0]                   take_n;

    assign busy = (r_state != S_IDLE);
    assign j4   = cim_pkg::DIDX_BITS'(r_j);
    assign idx  = (r_state == S_EDIT) ? r_denom[IW-1:0] : r_j;

    // count store and shared multiplier
    cim_store #(
        .DEPTH      (ND),
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (idx),
        .o_rd_data (rd_data),
        .i_we      (wr_en),
        .i_wr_idx  (idx),
        .i_wr_data (wr_data)
    );

    cim_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // denominations below the walk index that still have coins to give
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            below[k] = (k < int'(r_j)) && r_nz[k];
        end
    end

    // add path sum and capped take amount
    assign sum    = (WC+1)'(rd_data) + (WC+1)'(r_count);
    assign quot   = prod[PB-1 -: FB];
    assign take_n = (WC'(rd_data) < WC'(quot)) ? FB'(rd_data) : quot;

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_denom  = r_denom;
        n_count  = r_count;
        n_rem    = r_rem;
        n_j      = r_j;
        n_take   = r_take;
        n_nz     = r_nz;
        n_valid  = 1'b0;
        n_status = r_status;
        n_dout   = r_dout;
        n_cout   = r_cout;
        n_last   = r_last;
        wr_en    = 1'b0;
        wr_data  = rd_data;
        mul_a    = r_rem;
        mul_b    = cim_pkg::DENOM_RECIP[j4];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_denom = i_denom;
                    n_count = i_count;
                    n_rem   = i_amount;
                    n_j     = IW'(ND - 1);
                    n_nz    = '0;
                    if (i_func == cim_pkg::FN_ADD || i_func == cim_pkg::FN_REMOVE) begin
                        n_state = S_EDIT;
                    end else if (i_func == cim_pkg::FN_CHANGE) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_EDIT: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_dout  = r_denom;
                n_state = S_IDLE;
                if ({1'b0, r_denom} >= (cim_pkg::DIDX_BITS+1)'(ND)) begin
                    n_status = cim_pkg::ST_BAD_DENOM;
                    n_cout   = '0;
                end else if (r_func == cim_pkg::FN_ADD) begin
                    wr_en = 1'b1;
                    if (sum > COUNT_MAX) begin
                        wr_data  = {COUNT_BITS{1'b1}};
                        n_status = cim_pkg::ST_SATURATED;
                    end else begin
                        wr_data  = COUNT_BITS'(sum);
                        n_status = cim_pkg::ST_OK;
                    end
                    n_cout = FB'(wr_data);
                end else if (WC'(rd_data) >= WC'(r_count)) begin
                    wr_en    = 1'b1;
                    wr_data  = COUNT_BITS'(WC'(rd_data) - WC'(r_count));
                    n_status = cim_pkg::ST_OK;
                    n_cout   = FB'(wr_data);
                end else begin
                    n_status = cim_pkg::ST_SHORT;
                    n_cout   = FB'(rd_data);
                end
            end
            S_DIV: begin
                // quotient of remainder by face value via reciprocal
                n_state = S_CAP;
            end
            S_CAP: begin
                // cap at stored coins, then product of take and face value
                n_take[r_j] = take_n;
                n_nz[r_j]   = (take_n != '0);
                mul_a       = take_n;
                mul_b       = cim_pkg::MUL_B_BITS'(cim_pkg::DENOM_VALUE[j4]);
                n_state     = S_SUB;
            end
            S_SUB: begin
                n_rem = r_rem - prod[FB-1:0];
                if (r_j == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_j     = r_j - 1'b1;
                    n_state = S_DIV;
                end
            end
            S_CHECK: begin
                n_dout = '0;
                n_cout = '0;
                n_last = 1'b1;
                if (r_rem != '0) begin
                    n_valid  = 1'b1;
                    n_status = cim_pkg::ST_NO_CHANGE;
                    n_state  = S_IDLE;
                end else if (r_nz == '0) begin
                    n_valid  = 1'b1;
                    n_status = cim_pkg::ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_j     = IW'(ND - 1);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // commit and report each used denomination, largest first
                if (r_nz[r_j]) begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data - COUNT_BITS'(r_take[r_j]);
                    n_valid  = 1'b1;
                    n_status = cim_pkg::ST_OK;
                    n_dout   = j4;
                    n_cout   = r_take[r_j];
                    n_last   = (below == '0);
                end
                if ((r_nz[r_j] && below == '0) || r_j == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_func   <= n_func;
        r_denom  <= n_denom;
        r_count  <= n_count;
        r_rem    <= n_rem;
        r_j      <= n_j;
        r_take   <= n_take;
        r_nz     <= n_nz;
        r_status <= n_status;
        r_dout   <= n_dout;
        r_cout   <= n_cout;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_denom_out  = r_dout;
    assign o_coin_count = r_cout;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    // an accepted command with a result raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == cim_pkg::FN_ADD || i_func == cim_pkg::FN_REMOVE ||
                            i_func == cim_pkg::FN_CHANGE)) |=> busy)
        else $error("command accepted without going busy");

    // the final beat of a command is never followed by another beat
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result beat after final beat");

    // a no-change failure report is always the only beat
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cim_pkg::ST_NO_CHANGE) |-> o_last)
        else $error("no-change failure not marked last");

    // capped take times face value never exceeds the remainder
    a_sub_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |-> (prod[PB-1:FB] == '0 && prod[FB-1:0] <= r_rem))
        else $error("greedy take exceeds remaining amount");

    // busy has already dropped while the final beat is shown
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("still busy at final beat");
`endif

endmodule
